>>> sv/htu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htu_pkg
// Shared widths, action codes, payload types and saturation helpers for the
// homogeneous transform unit.
// ----------------------------------------------------------------------------
package htu_pkg;

    // Coordinate and coefficient formats (Q16.16 and Q4.12 at the defaults).
    localparam int COORD_WIDTH = 32;
    localparam int COEF_WIDTH  = 16;
    localparam int COORD_FRAC  = COORD_WIDTH / 2;
    localparam int COEF_FRAC   = COEF_WIDTH - 4;
    localparam int SUM_FRAC    = COORD_FRAC + COEF_FRAC;
    localparam int ROW_WIDTH   = 4 * COEF_WIDTH;

    // Product, lane sum and divider widths.
    localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 2;
    localparam int QUO_WIDTH   = COORD_WIDTH + 1;
    localparam int QUO_SHIFT   = QUO_WIDTH - COORD_FRAC;
    localparam int DIV_LAT     = QUO_WIDTH + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_WIDTH = 3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_FWD_ROW0 = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_FWD_ROW1 = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_FWD_ROW2 = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_FWD_ROW3 = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_INV_ROW0 = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_INV_ROW1 = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_INV_ROW2 = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_INV_ROW3 = 3'd7;

    // Action codes.
    localparam logic [2:0] ACT_POINT      = 3'd0;
    localparam logic [2:0] ACT_VECTOR     = 3'd1;
    localparam logic [2:0] ACT_NORMAL     = 3'd2;
    localparam logic [2:0] ACT_INV_POINT  = 3'd3;
    localparam logic [2:0] ACT_INV_VECTOR = 3'd4;
    localparam logic [2:0] ACT_INV_NORMAL = 3'd5;

    typedef struct packed {
        logic [2:0]                    action;
        logic signed [COORD_WIDTH-1:0] in_x;
        logic signed [COORD_WIDTH-1:0] in_y;
        logic signed [COORD_WIDTH-1:0] in_z;
    } t_in;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic                          fault;
    } t_out;

    // One saturated coordinate with its fault bit.
    typedef struct packed {
        logic                   flt;
        logic [COORD_WIDTH-1:0] val;
    } t_sat;

    // Divider entry: either a finished bypass value or a division job.
    typedef struct packed {
        logic                   bypass;
        logic                   neg;
        logic [SUM_WIDTH-1:0]   num;
        logic [SUM_WIDTH-1:0]   den;
        t_sat                   byp;
    } t_div_in;

    // State carried through one divider stage.
    typedef struct packed {
        logic                   bypass;
        logic                   neg;
        logic                   ovf;
        t_sat                   byp;
        logic [SUM_WIDTH-1:0]   den;
        logic [SUM_WIDTH-1:0]   rem;
        logic [QUO_WIDTH-1:0]   bits;
        logic [QUO_WIDTH-1:0]   quo;
    } t_div_st;

    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Apply a sign to a magnitude and clamp to the coordinate range.
    function automatic t_sat sat_mag(input logic neg, input logic [SUM_WIDTH-1:0] mag);
        t_sat res;
        res.flt = 1'b0;
        res.val = '0;
        if (!neg) begin
            if (mag > SUM_WIDTH'(COORD_MAX)) begin
                res.flt = 1'b1;
                res.val = COORD_MAX;
            end else begin
                res.val = mag[COORD_WIDTH-1:0];
            end
        end else begin
            if (mag > SUM_WIDTH'(COORD_MIN)) begin
                res.flt = 1'b1;
                res.val = COORD_MIN;
            end else begin
                res.val = COORD_WIDTH'(-mag[COORD_WIDTH-1:0]);
            end
        end
        return res;
    endfunction

    // Magnitude of a signed lane sum.
    function automatic logic [SUM_WIDTH-1:0] abs_sum(input logic signed [SUM_WIDTH-1:0] s);
        return s[SUM_WIDTH-1] ? SUM_WIDTH'(-s) : SUM_WIDTH'(s);
    endfunction

    // Drop the coefficient fraction bits, rounding half away from zero.
    function automatic t_sat narrow_sum(input logic signed [SUM_WIDTH-1:0] s);
        logic [SUM_WIDTH-1:0] mag;
        mag = abs_sum(s);
        mag = (mag >> COEF_FRAC) + SUM_WIDTH'(mag[COEF_FRAC-1]);
        return sat_mag(s[SUM_WIDTH-1], mag);
    endfunction

endpackage

>>> sv/htu_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htu_lane
// One row of the matrix product: three multiplies plus translation, summed.
// ----------------------------------------------------------------------------
module htu_lane (
    input  logic                                   i_clk,
    input  logic signed [htu_pkg::COORD_WIDTH-1:0] i_c0,
    input  logic signed [htu_pkg::COORD_WIDTH-1:0] i_c1,
    input  logic signed [htu_pkg::COORD_WIDTH-1:0] i_c2,
    input  logic signed [htu_pkg::COEF_WIDTH-1:0]  i_k0,
    input  logic signed [htu_pkg::COEF_WIDTH-1:0]  i_k1,
    input  logic signed [htu_pkg::COEF_WIDTH-1:0]  i_k2,
    input  logic signed [htu_pkg::COEF_WIDTH-1:0]  i_t,
    input  logic                                   i_point,
    output logic signed [htu_pkg::SUM_WIDTH-1:0]   o_sum
);

    logic signed [htu_pkg::PROD_WIDTH-1:0] r_p0, r_p1, r_p2;
    logic signed [htu_pkg::SUM_WIDTH-1:0]  r_t;
    logic signed [htu_pkg::SUM_WIDTH-1:0]  r_sum;

    // Stage one: the three products and the aligned translation term.
    always_ff @(posedge i_clk) begin
        r_p0 <= i_c0 * i_k0;
        r_p1 <= i_c1 * i_k1;
        r_p2 <= i_c2 * i_k2;
        r_t  <= i_point ? (htu_pkg::SUM_WIDTH'(i_t) <<< htu_pkg::COORD_FRAC) : '0;
    end

    // Stage two: exact sum.
    always_ff @(posedge i_clk) begin
        r_sum <= htu_pkg::SUM_WIDTH'(r_p0) + htu_pkg::SUM_WIDTH'(r_p1)
               + htu_pkg::SUM_WIDTH'(r_p2) + r_t;
    end

    assign o_sum = r_sum;

endmodule

>>> sv/htu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htu_div
// Pipelined restoring divider, one quotient bit per stage, with rounding and
// saturation at the end. Bypass entries ride along unchanged.
// ----------------------------------------------------------------------------
module htu_div (
    input  logic             i_clk,
    input  htu_pkg::t_div_in i_job,
    output htu_pkg::t_sat    o_res
);

    localparam int SW = htu_pkg::SUM_WIDTH;
    localparam int QW = htu_pkg::QUO_WIDTH;
    localparam int SH = htu_pkg::QUO_SHIFT;

    htu_pkg::t_div_st r_st [0:QW];

    // Entry stage: overflow check and initial partial remainder.
    always_ff @(posedge i_clk) begin
        r_st[0].bypass <= i_job.bypass;
        r_st[0].neg    <= i_job.neg;
        r_st[0].byp    <= i_job.byp;
        r_st[0].den    <= i_job.den;
        r_st[0].ovf    <= {{SH{1'b0}}, i_job.num} >= {i_job.den, {SH{1'b0}}};
        r_st[0].rem    <= i_job.num >> SH;
        r_st[0].bits   <= {i_job.num[SH-1:0], {htu_pkg::COORD_FRAC{1'b0}}};
        r_st[0].quo    <= '0;
    end

    // One quotient bit per stage.
    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [SW:0] rr;
        logic        ge;
        assign rr = {r_st[j].rem, r_st[j].bits[QW-1]};
        assign ge = rr >= {1'b0, r_st[j].den};
        always_ff @(posedge i_clk) begin
            r_st[j+1].bypass <= r_st[j].bypass;
            r_st[j+1].neg    <= r_st[j].neg;
            r_st[j+1].ovf    <= r_st[j].ovf;
            r_st[j+1].byp    <= r_st[j].byp;
            r_st[j+1].den    <= r_st[j].den;
            r_st[j+1].rem    <= ge ? SW'(rr - {1'b0, r_st[j].den}) : rr[SW-1:0];
            r_st[j+1].bits   <= {r_st[j].bits[QW-2:0], 1'b0};
            r_st[j+1].quo    <= {r_st[j].quo[QW-2:0], ge};
        end
    end

    // Round to nearest and saturate.
    always_comb begin
        logic        rnd;
        logic [SW-1:0] mag;
        rnd = {r_st[QW].rem, 1'b0} >= {1'b0, r_st[QW].den};
        mag = SW'(r_st[QW].quo) + SW'(rnd);
        if (r_st[QW].bypass) begin
            o_res = r_st[QW].byp;
        end else if (r_st[QW].ovf) begin
            o_res.flt = 1'b1;
            o_res.val = r_st[QW].neg ? htu_pkg::COORD_MIN : htu_pkg::COORD_MAX;
        end else begin
            o_res = htu_pkg::sat_mag(r_st[QW].neg, mag);
        end
    end

endmodule

>>> sv/homogeneous_transform_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_transform_unit
// 4x4 homogeneous transform of points, vectors and normals in fixed point.
// ----------------------------------------------------------------------------
// Usage: load the forward and inverse matrix rows through the configuration
// channel (i_cfg_valid / o_cfg_ready, register index and 64-bit row data;
// o_cfg_ready is always high). Write rows only while no item is in flight.
// Issue an item by raising i_start with i_item; o_busy stays low, so a new
// beat is taken every cycle. Four multiply lanes (x, y, z, w) form the row
// sums, a merge stage chooses between narrowing, zero-w saturation and
// division by w, and three pipelined dividers retire one quotient bit per
// stage. Every item takes the same path (input register, lane stages, merge
// register, divider stages, output register), so results leave in order,
// one per cycle.
// Each result is shown for exactly one cycle with o_done; the receiver cannot
// stall it. Reset empties the pipeline and loads identity matrices.
// ----------------------------------------------------------------------------
module homogeneous_transform_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    output logic                                    o_busy,
    input  htu_pkg::t_in                            i_item,
    output logic                                    o_done,
    output htu_pkg::t_out                           o_result,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [htu_pkg::CFG_IDX_WIDTH-1:0]       i_cfg_index,
    input  logic [htu_pkg::ROW_WIDTH-1:0]           i_cfg_data
);

    localparam int KW = htu_pkg::COEF_WIDTH;
    localparam int SW = htu_pkg::SUM_WIDTH;

    logic [htu_pkg::ROW_WIDTH-1:0] r_fwd [4];
    logic [htu_pkg::ROW_WIDTH-1:0] r_inv [4];

    logic                 r_v0, r_v1, r_v2, r_vm, r_done;
    logic [htu_pkg::DIV_LAT-1:0] r_vd;
    htu_pkg::t_in         r_in;
    logic [2:0]           r_act1, r_act2;
    htu_pkg::t_div_in     r_job [3];
    htu_pkg::t_out        r_result;

    logic signed [KW-1:0] n_k [4][3];
    logic signed [KW-1:0] n_t [4];
    logic                 n_point;
    logic signed [SW-1:0] w_sum [4];
    htu_pkg::t_div_in     n_job [3];
    htu_pkg::t_sat        w_res [3];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Matrix rows, identity after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 4; r++) begin
                r_fwd[r] <= htu_pkg::ROW_WIDTH'(1 << htu_pkg::COEF_FRAC) << (r * KW);
                r_inv[r] <= htu_pkg::ROW_WIDTH'(1 << htu_pkg::COEF_FRAC) << (r * KW);
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                htu_pkg::CFG_FWD_ROW0: r_fwd[0] <= i_cfg_data;
                htu_pkg::CFG_FWD_ROW1: r_fwd[1] <= i_cfg_data;
                htu_pkg::CFG_FWD_ROW2: r_fwd[2] <= i_cfg_data;
                htu_pkg::CFG_FWD_ROW3: r_fwd[3] <= i_cfg_data;
                htu_pkg::CFG_INV_ROW0: r_inv[0] <= i_cfg_data;
                htu_pkg::CFG_INV_ROW1: r_inv[1] <= i_cfg_data;
                htu_pkg::CFG_INV_ROW2: r_inv[2] <= i_cfg_data;
                htu_pkg::CFG_INV_ROW3: r_inv[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_vm   <= 1'b0;
            r_vd   <= '0;
            r_done <= 1'b0;
        end else begin
            r_v0   <= i_start;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            r_vm   <= r_v2;
            r_vd   <= {r_vd[htu_pkg::DIV_LAT-2:0], r_vm};
            r_done <= r_vd[htu_pkg::DIV_LAT-1];
        end
    end

    // Input beat and action delay alongside the lanes.
    always_ff @(posedge i_clk) begin
        r_in   <= i_item;
        r_act1 <= r_in.action;
        r_act2 <= r_act1;
    end

    // Coefficient selection: rows of the chosen matrix, or columns of the
    // other matrix for normals.
    always_comb begin
        logic inv, nrm;
        inv = (r_in.action == htu_pkg::ACT_INV_POINT)
           || (r_in.action == htu_pkg::ACT_INV_VECTOR)
           || (r_in.action == htu_pkg::ACT_INV_NORMAL);
        nrm = (r_in.action == htu_pkg::ACT_NORMAL)
           || (r_in.action == htu_pkg::ACT_INV_NORMAL);
        n_point = (r_in.action == htu_pkg::ACT_POINT)
               || (r_in.action == htu_pkg::ACT_INV_POINT);
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 3; k++) begin
                if (nrm) begin
                    n_k[i][k] = inv ? r_fwd[k][i*KW +: KW] : r_inv[k][i*KW +: KW];
                end else begin
                    n_k[i][k] = inv ? r_inv[i][k*KW +: KW] : r_fwd[i][k*KW +: KW];
                end
            end
            n_t[i] = inv ? r_inv[i][3*KW +: KW] : r_fwd[i][3*KW +: KW];
        end
    end

    // Four lanes: x, y, z and w.
    for (genvar i = 0; i < 4; i++) begin : g_lane
        htu_lane u_lane (
            .i_clk   (i_clk),
            .i_c0    (r_in.in_x),
            .i_c1    (r_in.in_y),
            .i_c2    (r_in.in_z),
            .i_k0    (n_k[i][0]),
            .i_k1    (n_k[i][1]),
            .i_k2    (n_k[i][2]),
            .i_t     (n_t[i]),
            .i_point (n_point),
            .o_sum   (w_sum[i])
        );
    end

    // Merge: decide per coordinate between a zero result for an invalid action,
    // narrowing, zero-w saturation and a division by w.
    always_comb begin
        logic pt, valid_act, w_one, w_zero;
        pt = (r_act2 == htu_pkg::ACT_POINT) || (r_act2 == htu_pkg::ACT_INV_POINT);
        valid_act = (r_act2 <= htu_pkg::ACT_INV_NORMAL);
        w_one  = (w_sum[3] == (SW'(1) << htu_pkg::SUM_FRAC));
        w_zero = (w_sum[3] == '0);
        for (int i = 0; i < 3; i++) begin
            n_job[i].bypass = 1'b1;
            n_job[i].neg    = w_sum[i][SW-1] ^ w_sum[3][SW-1];
            n_job[i].num    = htu_pkg::abs_sum(w_sum[i]);
            n_job[i].den    = htu_pkg::abs_sum(w_sum[3]);
            n_job[i].byp    = '0;
            if (!valid_act) begin
                n_job[i].byp = '0;
            end else if (pt && !w_one && w_zero) begin
                n_job[i].byp.flt = 1'b1;
                n_job[i].byp.val = w_sum[i][SW-1] ? htu_pkg::COORD_MIN : htu_pkg::COORD_MAX;
            end else if (pt && !w_one) begin
                n_job[i].bypass = 1'b0;
            end else begin
                n_job[i].byp = htu_pkg::narrow_sum(w_sum[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    // Three dividers, one per output coordinate.
    for (genvar i = 0; i < 3; i++) begin : g_div
        htu_div u_div (
            .i_clk (i_clk),
            .i_job (r_job[i]),
            .o_res (w_res[i])
        );
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        r_result.out_x <= w_res[0].val;
        r_result.out_y <= w_res[1].val;
        r_result.out_z <= w_res[2].val;
        r_result.fault <= w_res[0].flt | w_res[1].flt | w_res[2].flt;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
